// ===== hw/rtl/avt_pkg.sv =====
// Shared mode codes and pipeline control types for the affine vertex transform.
`timescale 1ns / 1ps

package avt_pkg;

	localparam int MODE_W = 3;
	localparam int INDEX_W = 4;
	localparam int LANES = 4;
	localparam int TERMS = 4;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FULL    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POINT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROTATE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INV_ROT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RIGID   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNTRANS = 3'd6;

	// Load enables for the two lane stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} avt_lane_ctl_t;

	// Load enable and incoming valid for the output register.
	typedef struct packed {
		logic load;
		logic valid;
	} avt_out_ctl_t;

endpackage

// ===== hw/rtl/avt_lane.sv =====
// One dot-product lane: four multiplies, then a saturating sum with an addend.
`timescale 1ns / 1ps

module avt_lane #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  avt_pkg::avt_lane_ctl_t        ctl,
	input  logic signed [DATA_WIDTH-1:0]  opa [avt_pkg::TERMS],
	input  logic signed [DATA_WIDTH-1:0]  coef [avt_pkg::TERMS],
	input  logic signed [DATA_WIDTH-1:0]  addend,
	output logic signed [DATA_WIDTH-1:0]  result,
	output logic                          sat
);

	import avt_pkg::*;

	localparam int PW = 2 * DATA_WIDTH - FRAC_BITS;
	localparam int SW = ((PW > DATA_WIDTH) ? PW : DATA_WIDTH) + 3;
	localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [2*DATA_WIDTH-1:0] mul [TERMS];
	logic signed [PW-1:0]           prod_s2 [TERMS];
	logic signed [DATA_WIDTH-1:0]   add_s2;
	logic signed [SW-1:0]           sum;
	logic                           sum_ovf;
	logic signed [DATA_WIDTH-1:0]   result_s3;
	logic                           sat_s3;

	always_comb begin
		for (int k = 0; k < TERMS; k++) begin
			mul[k] = opa[k] * coef[k];
		end
	end

	// Dropping the low fraction bits is an arithmetic shift, rounding toward minus infinity.
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			for (int k = 0; k < TERMS; k++) begin
				prod_s2[k] <= mul[k][2*DATA_WIDTH-1:FRAC_BITS];
			end
			add_s2 <= addend;
		end
	end

	always_comb begin
		sum = {{(SW-DATA_WIDTH){add_s2[DATA_WIDTH-1]}}, add_s2};
		for (int k = 0; k < TERMS; k++) begin
			sum = sum + {{(SW-PW){prod_s2[k][PW-1]}}, prod_s2[k]};
		end
		sum_ovf = !((&sum[SW-1:DATA_WIDTH-1]) || !(|sum[SW-1:DATA_WIDTH-1]));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			sat_s3 <= sum_ovf;
			if (sum_ovf) begin
				result_s3 <= sum[SW-1] ? MIN_V : MAX_V;
			end else begin
				result_s3 <= sum[DATA_WIDTH-1:0];
			end
		end
	end

	assign result = result_s3;
	assign sat = sat_s3;

endmodule

// ===== hw/rtl/avt_merge.sv =====
// Output register that gathers the lane results and folds their clamp flags.
`timescale 1ns / 1ps

module avt_merge #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  avt_pkg::avt_out_ctl_t         ctl,
	input  logic signed [DATA_WIDTH-1:0]  lane_res [avt_pkg::LANES],
	input  logic [avt_pkg::LANES-1:0]     lane_sat,
	input  logic                          pre_sat,
	output logic                          out_valid,
	output logic signed [DATA_WIDTH-1:0]  out_x,
	output logic signed [DATA_WIDTH-1:0]  out_y,
	output logic signed [DATA_WIDTH-1:0]  out_z,
	output logic signed [DATA_WIDTH-1:0]  out_w,
	output logic                          saturated
);

	import avt_pkg::*;

	logic                          valid_q;
	logic signed [DATA_WIDTH-1:0]  res_q [LANES];
	logic                          sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < LANES; i++) begin
				res_q[i] <= lane_res[i];
			end
			sat_q <= (|lane_sat) | pre_sat;
		end
	end

	assign out_valid = valid_q;
	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];
	assign out_w = res_q[3];
	assign saturated = sat_q;

endmodule

// ===== hw/rtl/affine_vertex_transform.sv =====
// Top level: matrix store, operand selection and the four-lane transform pipeline.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_ready  | mode, elem_index, elem_value, vec_x..vec_w
//  output  | out_valid/out_ready| out_x, out_y, out_z, out_w, saturated
//
// One request per clock while the output is not stalled. The edge that takes a request
// loads the operand stage; the multiply, sum-and-clamp and output registers follow in
// that order, and the result is offered from the output register.
// The sixteen lane multipliers run in parallel, so the rate is set by the pipeline alone.
// An element write lands at the edge that takes the request; later requests see it.
// Reset makes the matrix identity and empties the pipeline.
// A stalled output holds its result while the stages behind it keep filling.
`timescale 1ns / 1ps

module affine_vertex_transform #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [avt_pkg::MODE_W-1:0]        mode,
	input  logic [avt_pkg::INDEX_W-1:0]       elem_index,
	input  logic signed [DATA_WIDTH-1:0]      elem_value,
	input  logic signed [DATA_WIDTH-1:0]      vec_x,
	input  logic signed [DATA_WIDTH-1:0]      vec_y,
	input  logic signed [DATA_WIDTH-1:0]      vec_z,
	input  logic signed [DATA_WIDTH-1:0]      vec_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [DATA_WIDTH-1:0]      out_x,
	output logic signed [DATA_WIDTH-1:0]      out_y,
	output logic signed [DATA_WIDTH-1:0]      out_z,
	output logic signed [DATA_WIDTH-1:0]      out_w,
	output logic                              saturated
);

	import avt_pkg::*;

	localparam int ELEMS = 16;
	localparam logic [DATA_WIDTH-1:0] ONE_V = DATA_WIDTH'(1) << FRAC_BITS;
	localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [DATA_WIDTH-1:0] matrix_q [ELEMS];

	logic signed [DATA_WIDTH-1:0] vec [TERMS];
	logic signed [DATA_WIDTH:0]   diff [3];
	logic signed [DATA_WIDTH-1:0] dvec [3];
	logic [2:0]                   dsat;

	logic signed [DATA_WIDTH-1:0] opa_c [LANES][TERMS];
	logic signed [DATA_WIDTH-1:0] coef_c [LANES][TERMS];
	logic signed [DATA_WIDTH-1:0] add_c [LANES];
	logic                         pre_sat_c;

	logic signed [DATA_WIDTH-1:0] opa_s1 [LANES][TERMS];
	logic signed [DATA_WIDTH-1:0] coef_s1 [LANES][TERMS];
	logic signed [DATA_WIDTH-1:0] add_s1 [LANES];
	logic                         pre_sat_s1;
	logic                         pre_sat_s2;
	logic                         pre_sat_s3;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic ld_s1;
	logic ld_s2;
	logic ld_s3;
	logic ld_out;
	logic in_fire;

	logic signed [DATA_WIDTH-1:0] lane_res [LANES];
	logic [LANES-1:0]             lane_sat;
	avt_lane_ctl_t                lane_ctl;
	avt_out_ctl_t                 out_ctl;

	// Each stage loads when it is empty or the stage after it moves on.
	assign ld_out = !out_valid || out_ready;
	assign ld_s3 = !v_s3 || ld_out;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign in_ready = ld_s1;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ELEMS; e++) begin
				matrix_q[e] <= (e % 5 == 0) ? ONE_V : '0;
			end
		end else if (in_fire && mode == MODE_LOAD) begin
			matrix_q[elem_index] <= elem_value;
		end
	end

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	// v - t per component, clamped, for the rigid inverse and untranslate.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {vec[i][DATA_WIDTH-1], vec[i]}
				- {matrix_q[12+i][DATA_WIDTH-1], matrix_q[12+i]};
			dsat[i] = diff[i][DATA_WIDTH] != diff[i][DATA_WIDTH-1];
			if (dsat[i]) begin
				dvec[i] = diff[i][DATA_WIDTH] ? MIN_V : MAX_V;
			end else begin
				dvec[i] = diff[i][DATA_WIDTH-1:0];
			end
		end
	end

	// Route vector components and matrix elements to the lanes; lane i makes component i.
	always_comb begin
		pre_sat_c = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			add_c[i] = '0;
			for (int k = 0; k < TERMS; k++) begin
				opa_c[i][k] = '0;
				coef_c[i][k] = '0;
			end
		end
		case (mode) inside
			MODE_FULL: begin
				for (int i = 0; i < LANES; i++) begin
					for (int k = 0; k < TERMS; k++) begin
						opa_c[i][k] = vec[k];
						coef_c[i][k] = matrix_q[4'(4*k+i)];
					end
				end
			end
			MODE_POINT, MODE_ROTATE: begin
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++) begin
						opa_c[i][k] = vec[k];
						coef_c[i][k] = matrix_q[4'(4*k+i)];
					end
					if (mode == MODE_POINT) begin
						add_c[i] = matrix_q[4'(12+i)];
					end
				end
			end
			MODE_INV_ROT: begin
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++) begin
						opa_c[i][k] = vec[k];
						coef_c[i][k] = matrix_q[4'(4*i+k)];
					end
				end
			end
			MODE_RIGID: begin
				pre_sat_c = |dsat;
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++) begin
						opa_c[i][k] = dvec[k];
						coef_c[i][k] = matrix_q[4'(4*i+k)];
					end
				end
			end
			MODE_UNTRANS: begin
				pre_sat_c = |dsat;
				for (int i = 0; i < 3; i++) begin
					add_c[i] = dvec[i];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int i = 0; i < LANES; i++) begin
				add_s1[i] <= add_c[i];
				for (int k = 0; k < TERMS; k++) begin
					opa_s1[i][k] <= opa_c[i][k];
					coef_s1[i][k] <= coef_c[i][k];
				end
			end
			pre_sat_s1 <= pre_sat_c;
		end
		if (ld_s2) begin
			pre_sat_s2 <= pre_sat_s1;
		end
		if (ld_s3) begin
			pre_sat_s3 <= pre_sat_s2;
		end
	end

	assign lane_ctl.ld_s2 = ld_s2;
	assign lane_ctl.ld_s3 = ld_s3;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		avt_lane #(
			.DATA_WIDTH(DATA_WIDTH),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.ctl(lane_ctl),
			.opa(opa_s1[g]),
			.coef(coef_s1[g]),
			.addend(add_s1[g]),
			.result(lane_res[g]),
			.sat(lane_sat[g])
		);
	end

	assign out_ctl.load = ld_out;
	assign out_ctl.valid = v_s3;

	avt_merge #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(out_ctl),
		.lane_res(lane_res),
		.lane_sat(lane_sat),
		.pre_sat(pre_sat_s3),
		.out_valid(out_valid),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_w(out_w),
		.saturated(saturated)
	);

	// An element write is visible in the matrix on the next cycle.
	a_elem_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode == MODE_LOAD) |=> matrix_q[$past(elem_index)] == $past(elem_value))
		else $error("matrix element write lost");

	// With the output register empty, the whole pipeline can move and take a request.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

	// With every stage full and the output stalled, no request may be taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && out_valid && !out_ready) |-> !in_ready)
		else $error("request taken into a full pipeline");

	// The sum stage, when it holds an item and cannot load, keeps it.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ld_s3) |=> v_s3)
		else $error("sum stage dropped an item during a stall");

endmodule
